/* rtl/hcl_pkg.sv */
// Package for the hex cube line drawer: widths, limits and shared types.
// Used by the interfaces, the controller, the datapath and the top level.
package hcl_pkg;
	localparam int COORD_BITS = 12;
	localparam int MAX_STEPS = 63;
	localparam int IDX_BITS = 6;
	localparam int DIST_BITS = COORD_BITS + 2;
	localparam int NUM_BITS = COORD_BITS + IDX_BITS + 4;
	localparam int DIV_CNT_BITS = 5;
	localparam int DIV_ITERS = NUM_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t src_x;
		coord_t src_y;
		coord_t src_z;
		coord_t dst_x;
		coord_t dst_y;
		coord_t dst_z;
	} req_t;

	typedef struct packed {
		coord_t cell_x;
		coord_t cell_y;
		coord_t cell_z;
		logic [IDX_BITS-1:0] step_index;
		logic last;
		logic too_far;
	} cell_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic [1:0] axis;
		logic finish;
		logic next_step;
	} cmd_t;

	typedef struct packed {
		logic too_far;
		logic single;
		logic div_done;
		logic at_end;
	} stat_t;
endpackage

/* rtl/hcl_req_if.sv */
// Valid/ready channel carrying one line request.
// Depends on hcl_pkg.
interface hcl_req_if;
	logic valid;
	logic ready;
	hcl_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/hcl_cell_if.sv */
// Valid/ready channel carrying one path cell.
// Depends on hcl_pkg.
interface hcl_cell_if;
	logic valid;
	logic ready;
	hcl_pkg::cell_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/hcl_ctrl.sv */
// Controller state machine of the hex cube line drawer.
// Depends on hcl_pkg; drives the datapath through cmd_t and reads stat_t.
module hcl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input hcl_pkg::stat_t stat,
	output hcl_pkg::cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CHECK = 6'b000010,
		S_DSTART = 6'b000100,
		S_DWAIT = 6'b001000,
		S_FIN = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 2'd0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
		end
	end

	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		cmd = '0;
		cmd.axis = axis_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.too_far || stat.single) begin
					state_d = S_OUT;
				end else begin
					axis_d = 2'd0;
					state_d = S_DSTART;
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					if (axis_q == 2'd2) begin
						state_d = S_FIN;
					end else begin
						axis_d = axis_q + 2'd1;
						state_d = S_DSTART;
					end
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.at_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.next_step = 1'b1;
						axis_d = 2'd0;
						state_d = S_DSTART;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* rtl/hcl_dp.sv */
// Datapath of the hex cube line drawer: distance, shared restoring divider,
// rounding and the cube fix-up. Depends on hcl_pkg.
module hcl_dp (
	input logic clk,
	input logic arst_n,
	input hcl_pkg::req_t req,
	input hcl_pkg::cmd_t cmd,
	output hcl_pkg::stat_t stat,
	output hcl_pkg::cell_t tile
);
	localparam int CB = hcl_pkg::COORD_BITS;
	localparam int DB = hcl_pkg::DIST_BITS;
	localparam int NB = hcl_pkg::NUM_BITS;
	localparam int IB = hcl_pkg::IDX_BITS;

	logic signed [CB-1:0] s_q [3];
	logic signed [CB:0] dd_q [3];
	logic [DB-1:0] n_q;
	logic [IB-1:0] i_q;
	logic far_q, single_q;
	logic signed [NB-1:0] num_q [3];
	logic signed [NB-1:0] r_q [3];
	logic [NB-1:0] res_q [3];

	logic [NB-1:0] div_rem_q, div_quo_q, div_a_q;
	logic [hcl_pkg::DIV_CNT_BITS-1:0] div_cnt_q;
	logic div_busy_q, div_done_q;

	logic signed [CB:0] dl [3];
	logic [DB-1:0] sum_abs;
	logic signed [CB:0] a0, a1, a2;

	always_comb begin
		dl[0] = {req.dst_x[CB-1], req.dst_x} - {req.src_x[CB-1], req.src_x};
		dl[1] = {req.dst_y[CB-1], req.dst_y} - {req.src_y[CB-1], req.src_y};
		dl[2] = {req.dst_z[CB-1], req.dst_z} - {req.src_z[CB-1], req.src_z};
		a0 = dl[0] < 0 ? -dl[0] : dl[0];
		a1 = dl[1] < 0 ? -dl[1] : dl[1];
		a2 = dl[2] < 0 ? -dl[2] : dl[2];
		sum_abs = DB'(unsigned'(a0)) + DB'(unsigned'(a1)) + DB'(unsigned'(a2));
	end

	logic [DB-1:0] n_d;
	assign n_d = sum_abs >> 1;

	// Current numerator S*N + (D-S)*i and its magnitude doubled plus N.
	logic signed [NB-1:0] cur_num;
	logic [NB-1:0] cur_abs, div_a_d, two_n;
	assign cur_num = num_q[cmd.axis];
	assign cur_abs = cur_num < 0 ? NB'(-cur_num) : NB'(cur_num);
	assign div_a_d = (cur_abs << 1) + NB'(n_q);
	assign two_n = NB'(n_q) << 1;

	logic [NB:0] trial;
	assign trial = {div_rem_q, div_a_q[NB-1]} - {1'b0, two_n};

	logic signed [NB-1:0] q_signed, rn, resd;
	assign q_signed = cur_num < 0 ? -signed'(div_quo_q) : signed'(div_quo_q);
	assign rn = NB'(q_signed * signed'(NB'(n_q)));
	assign resd = rn - cur_num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == hcl_pkg::DIV_CNT_BITS'(hcl_pkg::DIV_ITERS - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q[0] <= req.src_x;
			s_q[1] <= req.src_y;
			s_q[2] <= req.src_z;
			for (int k = 0; k < 3; k++) begin
				dd_q[k] <= dl[k];
				num_q[k] <= '0;
			end
			n_q <= n_d;
			i_q <= '0;
			far_q <= n_d > DB'(hcl_pkg::MAX_STEPS);
			single_q <= (n_d == '0) || (dl[0] == 0 && dl[1] == 0 && dl[2] == 0);
		end else if (cmd.next_step) begin
			i_q <= i_q + 1'b1;
			for (int k = 0; k < 3; k++)
				num_q[k] <= num_q[k] + NB'(dd_q[k]);
		end else if (cmd.div_start && i_q == '0) begin
			for (int k = 0; k < 3; k++)
				num_q[k] <= NB'(s_q[k]) * signed'(NB'(n_q));
		end
		if (cmd.div_start) begin
			div_a_q <= (i_q == '0) ? '0 : div_a_d;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_a_q <= div_a_q << 1;
			if (!trial[NB]) begin
				div_rem_q <= trial[NB-1:0];
				div_quo_q <= {div_quo_q[NB-2:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[NB-2:0], div_a_q[NB-1]};
				div_quo_q <= {div_quo_q[NB-2:0], 1'b0};
			end
		end
		if (div_done_q) begin
			r_q[cmd.axis] <= q_signed;
			res_q[cmd.axis] <= resd < 0 ? NB'(-resd) : NB'(resd);
		end
	end

	// The first division starts before the step-zero numerators settle. At
	// step zero every coordinate divides exactly with no residual, so the cell
	// is the source with z recomputed from x and y.
	logic signed [NB-1:0] fx, fy, fz;
	always_comb begin
		fx = r_q[0];
		fy = r_q[1];
		fz = r_q[2];
		if (i_q == '0) begin
			fx = NB'(s_q[0]);
			fy = NB'(s_q[1]);
			fz = -NB'(s_q[0]) - NB'(s_q[1]);
		end else if (res_q[0] > res_q[1] && res_q[0] > res_q[2]) begin
			fx = -r_q[1] - r_q[2];
		end else if (res_q[1] > res_q[2]) begin
			fy = -r_q[0] - r_q[2];
		end else begin
			fz = -r_q[0] - r_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tile <= '0;
		end else if (cmd.finish) begin
			tile.cell_x <= fx[CB-1:0];
			tile.cell_y <= fy[CB-1:0];
			tile.cell_z <= fz[CB-1:0];
			tile.step_index <= i_q;
			tile.last <= (DB'(i_q) == n_q);
			tile.too_far <= 1'b0;
		end else if (far_q && !cmd.div_start && i_q == '0 && !div_busy_q) begin
			tile.cell_x <= '0;
			tile.cell_y <= '0;
			tile.cell_z <= '0;
			tile.step_index <= '0;
			tile.last <= 1'b1;
			tile.too_far <= 1'b1;
		end else if (single_q && !far_q && i_q == '0 && !div_busy_q) begin
			tile.cell_x <= s_q[0];
			tile.cell_y <= s_q[1];
			tile.cell_z <= s_q[2];
			tile.step_index <= '0;
			tile.last <= 1'b1;
			tile.too_far <= 1'b0;
		end
	end

	assign stat.too_far = far_q;
	assign stat.single = single_q;
	assign stat.div_done = div_done_q;
	assign stat.at_end = far_q || single_q || (DB'(i_q) == n_q);
endmodule

/* rtl/hex_cube_line_draw.sv */
// Top level of the hex cube line drawer: request and cell channels.
// Depends on hcl_pkg, hcl_req_if, hcl_cell_if, hcl_ctrl and hcl_dp.
//
// Each request gives two cube cells and yields the N+1 cells of the line
// between them, or one cell flagged too_far when N exceeds 63. Every cell of
// a path, the first included, needs three divisions on one shared restoring
// divider of 22 iterations, run in turn through S_DSTART and S_DWAIT, and a
// finished cell is held in S_OUT until the output is ready. A single cell or
// a too_far result goes from S_CHECK straight to S_OUT after its request is
// taken. A new request is taken only after the last cell is delivered.
module hex_cube_line_draw (
	input logic clk,
	input logic arst_n,
	hcl_req_if.sink req,
	hcl_cell_if.source tile
);
	hcl_pkg::cmd_t cmd;
	hcl_pkg::stat_t stat;

	hcl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(tile.valid),
		.out_ready(tile.ready),
		.stat(stat),
		.cmd(cmd)
	);

	hcl_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.data),
		.cmd(cmd),
		.stat(stat),
		.tile(tile.data)
	);
endmodule

/* test/tb_hex_cube_line_draw.sv */
// Self-checking testbench for the hex cube line drawer: directed table, then random requests.
// Depends on hcl_pkg, hcl_req_if, hcl_cell_if and the hex_cube_line_draw top level.
module tb_hex_cube_line_draw;
	timeunit 1ns;
	timeprecision 1ps;
	import hcl_pkg::*;

	typedef struct {
		req_t rq;
		logic has_cell;
		cell_t c0;
	} row_t;

	logic clk;
	logic arst_n;
	hcl_req_if req ();
	hcl_cell_if tile ();

	hex_cube_line_draw DUT (.clk(clk), .arst_n(arst_n), .req(req), .tile(tile));

	cell_t path_cells[$];
	cell_t typed_cells[$];
	logic typed_valid[$];
	int errors = 0;
	int src_idle = 0;
	int snk_stall = 0;
	logic hold_off = 0;
	logic stim_done = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("** hex_cube_line_draw: FAILED **");
		$finish;
	end

	function automatic longint rnd_div(longint num, longint den);
		longint a;
		longint q;
		a = num < 0 ? -num : num;
		q = (2 * a + den) / (2 * den);
		return num < 0 ? -q : q;
	endfunction

	function automatic cell_t mk(longint x, longint y, longint z, int i, bit l, bit f);
		cell_t c;
		c.cell_x = coord_t'(x);
		c.cell_y = coord_t'(y);
		c.cell_z = coord_t'(z);
		c.step_index = i[IDX_BITS-1:0];
		c.last = l;
		c.too_far = f;
		return c;
	endfunction

	task automatic predict_path(req_t r);
		longint s[3];
		longint d[3];
		longint n;
		longint num[3];
		longint q[3];
		longint res[3];
		s[0] = r.src_x; s[1] = r.src_y; s[2] = r.src_z;
		d[0] = r.dst_x; d[1] = r.dst_y; d[2] = r.dst_z;
		n = 0;
		for (int k = 0; k < 3; k++) n += (d[k] > s[k]) ? d[k] - s[k] : s[k] - d[k];
		n = n / 2;
		if (n > MAX_STEPS) begin
			path_cells.insert(path_cells.size(), mk(0, 0, 0, 0, 1, 1));
		end else if (n == 0) begin
			path_cells.insert(path_cells.size(), mk(s[0], s[1], s[2], 0, 1, 0));
		end else begin
			for (longint i = 0; i <= n; i++) begin
				for (int k = 0; k < 3; k++) begin
					num[k] = s[k] * n + (d[k] - s[k]) * i;
					q[k] = rnd_div(num[k], n);
					res[k] = q[k] * n - num[k];
					if (res[k] < 0) res[k] = -res[k];
				end
				if (res[0] > res[1] && res[0] > res[2]) q[0] = -q[1] - q[2];
				else if (res[1] > res[2]) q[1] = -q[0] - q[2];
				else q[2] = -q[0] - q[1];
				path_cells.insert(path_cells.size(),
					mk(q[0], q[1], q[2], int'(i), i == n, 0));
			end
		end
	endtask

	function automatic req_t mkreq(int sx, int sy, int sz, int dx, int dy, int dz);
		req_t r;
		r.src_x = coord_t'(sx); r.src_y = coord_t'(sy); r.src_z = coord_t'(sz);
		r.dst_x = coord_t'(dx); r.dst_y = coord_t'(dy); r.dst_z = coord_t'(dz);
		return r;
	endfunction

	function automatic req_t rand_req();
		int sx, sy, dx, dy, dz, n;
		req_t r;
		sx = $urandom_range(4095) - 2048;
		sy = $urandom_range(4095) - 2048;
		if ($urandom_range(9) == 0) begin
			r = req_t'({$urandom, $urandom, 8'($urandom)});
		end else begin
			if ($urandom_range(3) == 0) begin
				sx = $urandom_range(2047, 1000);
				sy = -sx;
			end else begin
				sx = $urandom_range(1000) - 500;
				sy = $urandom_range(1000) - 500;
			end
			n = ($urandom_range(7) == 0) ? $urandom_range(70, 40) : $urandom_range(12);
			dx = $urandom_range(2 * n) - n;
			dy = $urandom_range(2 * n) - n;
			dz = -dx - dy;
			if ($urandom_range(5) == 0) dz = dz + $urandom_range(4) - 2;
			r = mkreq(sx, sy, -sx - sy, sx + dx, sy + dy, -sx - sy + dz);
		end
		return r;
	endfunction

	task automatic send(req_t r, logic has, cell_t c0);
		while (src_idle > 0 && $urandom_range(99) < src_idle) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.data <= r;
		predict_path(r);
		typed_valid.insert(typed_valid.size(), has);
		typed_cells.insert(typed_cells.size(), c0);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	initial begin
		row_t tbl[$];
		row_t rw;
		req.valid = 0;
		req.data = '0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		rw.has_cell = 1; rw.rq = mkreq(0, 0, 0, 0, 0, 0); rw.c0 = mk(0, 0, 0, 0, 1, 0);
		tbl.insert(tbl.size(), rw);
		rw.rq = mkreq(2047, -2048, 1, 2047, -2048, 1); rw.c0 = mk(2047, -2048, 1, 0, 1, 0);
		tbl.insert(tbl.size(), rw);
		rw.rq = mkreq(-2048, 2047, 1, 2047, -2048, 1); rw.c0 = mk(0, 0, 0, 0, 1, 1);
		tbl.insert(tbl.size(), rw);
		rw.rq = mkreq(5, 5, 5, 6, 5, 5); rw.c0 = mk(5, 5, 5, 0, 1, 0);
		tbl.insert(tbl.size(), rw);
		rw.rq = mkreq(0, 0, 0, 64, -64, 0); rw.c0 = mk(0, 0, 0, 0, 1, 1);
		tbl.insert(tbl.size(), rw);
		rw.has_cell = 0;
		tbl.insert(tbl.size(), '{mkreq(0, 0, 0, 63, -63, 0), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(0, 0, 0, 1, -1, 0), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(0, 0, 0, 3, 0, -3), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(2040, -2040, 0, 2047, -2047, 0), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(-2048, 2047, 1, -2045, 2047, -2), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(0, 0, 0, 2, 1, -3), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(10, 20, 30, 13, 18, 35), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(-1, -1, 2, -2047, -2047, 2047), 0, '0});
		tbl.insert(tbl.size(), '{mkreq(2047, 2047, 2047, 2040, 2044, 2046), 0, '0});
		foreach (tbl[k]) send(tbl[k].rq, tbl[k].has_cell, tbl[k].c0);
		for (int ph = 0; ph < 4; ph++) begin
			src_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 74 : 14) : 0;
			snk_stall = (ph == 2) ? 74 : (ph == 3 ? 14 : 0);
			for (int k = 0; k < 46; k++) send(rand_req(), 0, '0);
			if (ph == 0) begin
				hold_off <= 1;
				send(rand_req(), 0, '0);
				send(rand_req(), 0, '0);
				hold_off <= 0;
			end
			req.valid <= 0;
			while (path_cells.size() != 0) @(posedge clk);
		end
		stim_done <= 1;
	end

	initial begin
		int n;
		bit held;
		tile.ready = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1;
				tile.ready <= 0;
				n = 3000;
				repeat (n) @(posedge clk);
			end
			tile.ready <= !($urandom_range(99) < snk_stall);
		end
	end

	initial begin
		cell_t want;
		logic first;
		first = 1;
		forever begin
			@(posedge clk);
			if (tile.valid && tile.ready) begin
				if (path_cells.size() == 0) begin
					$display("%0t: unexpected cell %p", $time, tile.data);
					errors++;
				end else begin
					want = path_cells.pop_front();
					if (first && typed_valid.size() > 0) begin
						if (typed_valid[0] && typed_cells[0] != want) begin
							$display("%0t: table/prediction disagree exp %p got %p", $time,
								typed_cells[0], want);
							errors++;
						end
						void'(typed_valid.pop_front());
						void'(typed_cells.pop_front());
					end
					if (tile.data.cell_x !== want.cell_x || tile.data.cell_y !== want.cell_y ||
						tile.data.cell_z !== want.cell_z ||
						tile.data.step_index !== want.step_index ||
						tile.data.last !== want.last || tile.data.too_far !== want.too_far) begin
						$display("%0t: mismatch exp %p got %p", $time, want, tile.data);
						errors++;
					end
					first = want.last;
				end
			end
		end
	end

	initial begin
		@(posedge stim_done);
		repeat (200) @(posedge clk);
		if (errors == 0 && path_cells.size() == 0) begin
			$display("** hex_cube_line_draw: PASSED **");
		end else begin
			$display("** hex_cube_line_draw: FAILED **");
		end
		$finish;
	end
endmodule
